// File: rtl/vch_pkg.sv
// shared types, constants and helper functions for the voxel hash chain builder
// no dependencies; imported by every module of the block but vch_ram

package vch_pkg;

    localparam int COORD_W  = 32;
    localparam int HASH_W   = 32;
    localparam int HB_W     = 4;
    localparam int ENTRY_W  = 12;
    localparam int BUCKET_W = 13;
    localparam int LINK_W   = 13;
    localparam int EPOCH_W  = 8;

    localparam int VALUE_CAPACITY_DEF   = 4096;
    localparam int BUCKET_COUNT_MAX_DEF = 8192;

    localparam logic [HB_W-1:0] HASH_BITS_RST = 4'd13;

    localparam logic [HASH_W-1:0] PRIME_X  = 32'd73856093;
    localparam logic [HASH_W-1:0] PRIME_Y  = 32'd19349663;
    localparam logic [HASH_W-1:0] PRIME_Z  = 32'd83492791;
    localparam logic [HASH_W-1:0] MIX_MUL1 = 32'h7feb352d;
    localparam logic [HASH_W-1:0] MIX_MUL2 = 32'h846ca68b;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HASH,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_LOOKUP,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic clear;
        logic occupied;
    } cmd_kind_t;

    typedef struct packed {
        logic sweep;
    } back_status_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]  entry_index;
        logic [BUCKET_W-1:0] bucket;
        logic [LINK_W-1:0]   chain_link;
        logic                linked;
        logic                dropped;
    } result_t;

    function automatic logic [HASH_W-1:0] xs16(input logic [HASH_W-1:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [HASH_W-1:0] xs15(input logic [HASH_W-1:0] v);
        return v ^ (v >> 15);
    endfunction

endpackage

// File: rtl/voxel_coord_hash_chain_builder.sv
// top level of the voxel hash chain builder: ports, hash_bits register, front/queue/back
// depends on vch_pkg, vch_front, vch_queue, vch_back (and vch_ram below it)
//
//   channel   dir  handshake          payload
//   s_        in   s_tvalid/s_tready  s_tdata: coord_x, coord_y, coord_z; s_tuser: mode, occupied
//   m_        out  m_tvalid/m_tready  m_tdata: entry_index, bucket, chain_link; m_tuser: linked, dropped
//   cfg_      in   cfg_we             cfg_wdata: hash_bits
//
// the front end computes an insert's hash as 13 products on its one 32x32 multiplier,
// one after another between accept and hand-off, and takes no new item until then;
// a clear skips the hash in the front end and is handled in the back end's idle state
// after reset, and after every 255th clear, a clearing pass writes all BUCKET_COUNT_MAX
// entries (8192 by default) of the bucket head ram, one entry a cycle, with s_tready low
// a stalled m_ side holds the result register; up to two commands queue behind it

module voxel_coord_hash_chain_builder import vch_pkg::*; #(
    parameter int VALUE_CAPACITY   = VALUE_CAPACITY_DEF,
    parameter int BUCKET_COUNT_MAX = BUCKET_COUNT_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [95:0]       s_tdata,   // coord_x, coord_y, coord_z
    input  logic [1:0]        s_tuser,   // mode, occupied
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // entry_index, bucket, chain_link, zero fill
    output logic [1:0]        m_tuser,   // linked, dropped
    input  logic              cfg_we,
    input  logic [HB_W-1:0]   cfg_wdata  // hash_bits
);

    localparam int BKT_AW = $clog2(BUCKET_COUNT_MAX);
    localparam int CMD_W  = $bits(cmd_kind_t) + BKT_AW;

    logic [HB_W-1:0]   hash_bits_reg, hash_bits_next;
    back_status_t      status;
    logic              f_valid, f_ready, q_valid, q_ready;
    cmd_kind_t         f_kind, q_kind;
    logic [BKT_AW-1:0] f_bucket, q_bucket;
    logic [CMD_W-1:0]  q_data;
    result_t           res;

    assign hash_bits_next = cfg_we ? cfg_wdata : hash_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_bits_reg <= HASH_BITS_RST;
        end else begin
            hash_bits_reg <= hash_bits_next;
        end
    end

    vch_front #(
        .BUCKET_COUNT_MAX (BUCKET_COUNT_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_mode     (s_tuser[0]),
        .s_x        (s_tdata[31:0]),
        .s_y        (s_tdata[63:32]),
        .s_z        (s_tdata[95:64]),
        .s_occupied (s_tuser[1]),
        .hash_bits  (hash_bits_reg),
        .status     (status),
        .cmd_valid  (f_valid),
        .cmd_ready  (f_ready),
        .cmd_kind   (f_kind),
        .cmd_bucket (f_bucket)
    );

    vch_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_kind, f_bucket}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    assign q_kind   = q_data[CMD_W-1 -: $bits(cmd_kind_t)];
    assign q_bucket = q_data[BKT_AW-1:0];

    vch_back #(
        .VALUE_CAPACITY   (VALUE_CAPACITY),
        .BUCKET_COUNT_MAX (BUCKET_COUNT_MAX)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_kind    (q_kind),
        .q_bucket  (q_bucket),
        .status    (status),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {2'b00, res.chain_link, res.bucket, res.entry_index};
    assign m_tuser = {res.dropped, res.linked};

`ifndef ASSERT_OFF
    a_front_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("front accepted two items back to back");

    a_dropped_not_linked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata[37:25] == 13'd0)
            && (m_tdata[11:0] == 12'd0))
        else $error("dropped entry carries a link or an index");

    a_link_points_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[37:25] <= {1'b0, m_tdata[11:0]})
        else $error("chain link does not point to an earlier entry");
`endif

endmodule

// File: rtl/vch_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module vch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/vch_front.sv
// front end: accepts items, runs the spatial hash on one shared multiplier
// depends on vch_pkg

module vch_front import vch_pkg::*; #(
    parameter int BUCKET_COUNT_MAX = BUCKET_COUNT_MAX_DEF,
    localparam int BKT_AW = $clog2(BUCKET_COUNT_MAX)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [COORD_W-1:0]  s_x,
    input  logic [COORD_W-1:0]  s_y,
    input  logic [COORD_W-1:0]  s_z,
    input  logic                s_occupied,
    input  logic [HB_W-1:0]     hash_bits,
    input  back_status_t        status,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output cmd_kind_t           cmd_kind,
    output logic [BKT_AW-1:0]   cmd_bucket
);

    localparam logic [3:0] S_XP  = 4'd0;
    localparam logic [3:0] S_XC1 = 4'd1;
    localparam logic [3:0] S_YP  = 4'd3;
    localparam logic [3:0] S_YC1 = 4'd4;
    localparam logic [3:0] S_HY1 = 4'd6;
    localparam logic [3:0] S_ZP  = 4'd8;
    localparam logic [3:0] S_ZC1 = 4'd9;
    localparam logic [3:0] S_HZ1 = 4'd11;
    localparam logic [3:0] S_HZ2 = 4'd12;

    localparam logic [HASH_W-1:0] CAP_MASK = HASH_W'(BUCKET_COUNT_MAX - 1);

    front_state_t state_reg, state_next;
    logic [3:0]         step_reg, step_next;
    logic [HASH_W-1:0]  acc_reg, acc_next;
    logic [HASH_W-1:0]  h_reg, h_next;
    logic [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic               clear_reg, occ_reg;
    logic [HB_W-1:0]    hb_reg;
    logic [HASH_W-1:0]  op_a, op_b, hash, lo_mask;
    logic               accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: begin
                if (accept) begin
                    state_next = s_mode ? FR_HASH : FR_PUSH;
                end
            end
            FR_HASH: begin
                if (step_reg == S_HZ2) begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (cmd_ready) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == FR_IDLE) && !status.sweep;
        cmd_valid = (state_reg == FR_PUSH);
        case (step_reg)
            S_XP: begin
                op_a = x_reg;
                op_b = PRIME_X;
            end
            S_YP: begin
                op_a = y_reg;
                op_b = PRIME_Y;
            end
            S_ZP: begin
                op_a = z_reg;
                op_b = PRIME_Z;
            end
            S_XC1, S_YC1, S_ZC1: begin
                op_a = xs16(acc_reg);
                op_b = MIX_MUL1;
            end
            S_HY1, S_HZ1: begin
                op_a = xs16(h_reg ^ xs16(acc_reg));
                op_b = MIX_MUL1;
            end
            default: begin
                op_a = xs15(acc_reg);
                op_b = MIX_MUL2;
            end
        endcase
        acc_next  = acc_reg;
        h_next    = h_reg;
        step_next = step_reg;
        if (state_reg == FR_IDLE) begin
            step_next = S_XP;
        end else if (state_reg == FR_HASH) begin
            acc_next  = op_a * op_b;
            step_next = step_reg + 4'd1;
            if ((step_reg == S_YP) || (step_reg == S_ZP)) begin
                h_next = xs16(acc_reg);
            end
        end
        hash       = xs16(acc_reg);
        lo_mask    = (32'd1 << hb_reg) - 32'd1;
        cmd_bucket = BKT_AW'(hash & lo_mask & CAP_MASK);
        cmd_kind.clear    = clear_reg;
        cmd_kind.occupied = occ_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        acc_reg  <= acc_next;
        h_reg    <= h_next;
        if (accept) begin
            x_reg     <= s_x;
            y_reg     <= s_y;
            z_reg     <= s_z;
            clear_reg <= !s_mode;
            occ_reg   <= s_occupied;
            hb_reg    <= hash_bits;
        end
    end

endmodule

// File: rtl/vch_queue.sv
// two-entry command queue between the front and back ends
// depends on vch_pkg

module vch_queue import vch_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             push, pop;

    always_comb begin
        wr_ready  = (fill_reg != 2'd2);
        rd_valid  = (fill_reg != 2'd0);
        rd_data   = slot_reg[rptr_reg];
        push      = wr_valid && wr_ready;
        pop       = rd_valid && rd_ready;
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = pop ? !rptr_reg : rptr_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/vch_back.sv
// back end: bucket head read-modify-write, entry counter, epoch clear, result register
// depends on vch_pkg and vch_ram

module vch_back import vch_pkg::*; #(
    parameter int VALUE_CAPACITY   = VALUE_CAPACITY_DEF,
    parameter int BUCKET_COUNT_MAX = BUCKET_COUNT_MAX_DEF,
    localparam int BKT_AW = $clog2(BUCKET_COUNT_MAX)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  cmd_kind_t         q_kind,
    input  logic [BKT_AW-1:0] q_bucket,
    output back_status_t      status,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    localparam int CNT_W = $clog2(VALUE_CAPACITY + 1);
    localparam int MEM_W = EPOCH_W + CNT_W;
    localparam logic [CNT_W-1:0]   CAP       = CNT_W'(VALUE_CAPACITY);
    localparam logic [BKT_AW-1:0]  SWEEP_END = BKT_AW'(BUCKET_COUNT_MAX - 1);
    localparam logic [EPOCH_W-1:0] EPOCH_TOP = '1;

    back_state_t state_reg, state_next;
    logic [BKT_AW-1:0]  sweep_reg, sweep_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   link_reg, link_next;
    logic [BKT_AW-1:0]  bucket_reg, bucket_next;
    logic               linked_reg, linked_next;
    logic               dropped_reg, dropped_next;
    logic               out_valid_reg, out_valid_next;
    result_t            res_reg, res_next;

    logic               mem_we, mem_re;
    logic [BKT_AW-1:0]  mem_waddr, mem_raddr;
    logic [MEM_W-1:0]   mem_wdata, mem_rdata;
    logic [EPOCH_W-1:0] rd_epoch;
    logic [CNT_W-1:0]   rd_head;
    logic               out_free, full;

    assign rd_epoch = mem_rdata[MEM_W-1 -: EPOCH_W];
    assign rd_head  = mem_rdata[CNT_W-1:0];
    assign out_free = !out_valid_reg || res_ready;
    assign full     = (count_reg >= CAP);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_SWEEP: begin
                if (sweep_reg == SWEEP_END) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (q_valid) begin
                    if (q_kind.clear) begin
                        state_next = (epoch_reg == EPOCH_TOP) ? BK_SWEEP : BK_IDLE;
                    end else if (!full && q_kind.occupied) begin
                        state_next = BK_LOOKUP;
                    end else begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_LOOKUP: state_next = BK_EMIT;
            BK_EMIT: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_ready        = (state_reg == BK_IDLE);
        status.sweep   = (state_reg == BK_SWEEP);
        sweep_next     = sweep_reg;
        epoch_next     = epoch_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        link_next      = link_reg;
        bucket_next    = bucket_reg;
        linked_next    = linked_reg;
        dropped_next   = dropped_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !res_ready;
        mem_we         = 1'b0;
        mem_waddr      = bucket_reg;
        mem_wdata      = {epoch_reg, idx_reg + CNT_W'(1)};
        mem_re         = 1'b0;
        mem_raddr      = q_bucket;
        case (state_reg)
            BK_SWEEP: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '0;
                sweep_next = sweep_reg + BKT_AW'(1);
                if (sweep_reg == SWEEP_END) begin
                    epoch_next = EPOCH_W'(1);
                end
            end
            BK_IDLE: begin
                if (q_valid) begin
                    if (q_kind.clear) begin
                        count_next = '0;
                        sweep_next = '0;
                        epoch_next = epoch_reg + EPOCH_W'(1);
                    end else begin
                        bucket_next = q_bucket;
                        link_next   = '0;
                        if (full) begin
                            idx_next     = '0;
                            linked_next  = 1'b0;
                            dropped_next = 1'b1;
                        end else begin
                            idx_next     = count_reg;
                            count_next   = count_reg + CNT_W'(1);
                            linked_next  = q_kind.occupied;
                            dropped_next = 1'b0;
                            mem_re       = q_kind.occupied;
                        end
                    end
                end
            end
            BK_LOOKUP: begin
                link_next = (rd_epoch == epoch_reg) ? rd_head : '0;
                mem_we    = 1'b1;
            end
            BK_EMIT: begin
                if (out_free) begin
                    out_valid_next       = 1'b1;
                    res_next.entry_index = ENTRY_W'(idx_reg);
                    res_next.bucket      = BUCKET_W'(bucket_reg);
                    res_next.chain_link  = LINK_W'(link_reg);
                    res_next.linked      = linked_reg;
                    res_next.dropped     = dropped_reg;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        res_valid = out_valid_reg;
        res       = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_SWEEP;
            sweep_reg     <= '0;
            epoch_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            epoch_reg     <= epoch_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        link_reg    <= link_next;
        bucket_reg  <= bucket_next;
        linked_reg  <= linked_next;
        dropped_reg <= dropped_next;
        res_reg     <= res_next;
    end

    vch_ram #(
        .WIDTH (MEM_W),
        .DEPTH (BUCKET_COUNT_MAX)
    ) u_heads (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// File: dv/vch_tb_pkg.sv
`timescale 1ns / 1ps
// command codes shared by the stimulus and the checker of the voxel hash chain builder
// no dependencies

package vch_tb_pkg;

    typedef enum logic {
        MODE_CLEAR  = 1'b0,
        MODE_INSERT = 1'b1
    } tb_mode_t;

endpackage

// File: dv/vch_chain_checker.sv
`timescale 1ns / 1ps
// watches the s_, m_ and cfg_ ports of the voxel hash chain builder, rebuilds the bucket
// chains on its own and compares every result item with the oldest one it has predicted
// depends on vch_pkg (widths, primes, result layout) and vch_tb_pkg (command codes)

module vch_chain_checker import vch_pkg::*, vch_tb_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  logic [95:0]     s_tdata,
    input  logic [1:0]      s_tuser,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [39:0]     m_tdata,
    input  logic [1:0]      m_tuser,
    input  logic            cfg_we,
    input  logic [HB_W-1:0] cfg_wdata,
    output int              fail_count,
    output int              results_owed
);

    localparam int CAPACITY = VALUE_CAPACITY_DEF;
    localparam int NBUCKETS = BUCKET_COUNT_MAX_DEF;

    logic [HB_W-1:0]   hash_bits;
    logic [LINK_W-1:0] head_of[NBUCKETS];
    logic              head_live[NBUCKETS];
    logic [12:0]       entries;
    result_t           owed_q[$];
    int                fails = 0;

    function automatic logic [31:0] lowbias_mix(input logic [31:0] v);
        logic [31:0] m;
        m = v ^ (v >> 16);
        m = m * MIX_MUL1;
        m = m ^ (m >> 15);
        m = m * MIX_MUL2;
        return m ^ (m >> 16);
    endfunction

    function automatic logic [31:0] voxel_hash(input logic [31:0] x, y, z);
        logic [31:0] h;
        logic [31:0] px, py, pz;
        px = x * PRIME_X;
        py = y * PRIME_Y;
        pz = z * PRIME_Z;
        h = lowbias_mix(px);
        h = lowbias_mix(h ^ lowbias_mix(py));
        h = lowbias_mix(h ^ lowbias_mix(pz));
        return h;
    endfunction

    // hashes one entry and, if it is occupied and the table is not full, links it into its bucket chain
    function automatic result_t chain_entry(input logic [31:0] x, y, z, input logic occ);
        result_t             r;
        logic [31:0]         mask;
        logic [31:0]         h;
        logic [BUCKET_W-1:0] b;
        mask = ((32'd1 << hash_bits) - 32'd1) & (NBUCKETS - 1);
        h = voxel_hash(x, y, z) & mask;
        b = h[BUCKET_W-1:0];
        r = '0;
        r.bucket = b;
        if (entries >= CAPACITY) begin
            r.dropped = 1'b1;
        end else begin
            r.entry_index = entries[ENTRY_W-1:0];
            if (occ) begin
                r.chain_link = head_live[b] ? head_of[b] : '0;
                head_of[b] = LINK_W'(entries + 13'd1);
                head_live[b] = 1'b1;
                r.linked = 1'b1;
            end
            entries = entries + 13'd1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            hash_bits = HASH_BITS_RST;
            entries = '0;
            foreach (head_live[i]) head_live[i] = 1'b0;
            owed_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == MODE_CLEAR) begin
                    entries = '0;
                    foreach (head_live[i]) head_live[i] = 1'b0;
                end else begin
                    owed_q.insert(owed_q.size(),
                                  chain_entry(s_tdata[31:0], s_tdata[63:32],
                                              s_tdata[95:64], s_tuser[1]));
                end
            end
            if (m_tvalid && m_tready) begin
                got.entry_index = m_tdata[11:0];
                got.bucket      = m_tdata[24:12];
                got.chain_link  = m_tdata[37:25];
                got.linked      = m_tuser[0];
                got.dropped     = m_tuser[1];
                if (owed_q.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual %0d/%0d",
                             $time, got.entry_index, got.bucket);
                    fails++;
                end else begin
                    want = owed_q.pop_front();
                    check_field("entry_index", want.entry_index, got.entry_index);
                    check_field("bucket", want.bucket, got.bucket);
                    check_field("chain_link", want.chain_link, got.chain_link);
                    check_field("linked", want.linked, got.linked);
                    check_field("dropped", want.dropped, got.dropped);
                end
            end
            if (cfg_we) hash_bits = cfg_wdata;
        end
        fail_count   <= fails;
        results_owed <= owed_q.size();
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// top of the voxel hash chain builder testbench: clock, reset, stimulus and verdict
// depends on vch_pkg, vch_tb_pkg, vch_chain_checker and the block itself

module tb_top import vch_pkg::*, vch_tb_pkg::*;;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic [95:0]       s_tdata   = '0;
    logic [1:0]        s_tuser   = '0;
    logic              m_tready  = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [HB_W-1:0]   cfg_wdata = '0;
    logic              s_tready;
    logic              m_tvalid;
    logic [39:0]       m_tdata;
    logic [1:0]        m_tuser;
    int                fail_count;
    int                results_owed;
    bit                s_gaps    = 1'b1;
    bit                m_stalls  = 1'b1;
    int                stall_left = 0;

    voxel_coord_hash_chain_builder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    vch_chain_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) m_tready <= 1'b1;
        end else if (m_stalls && $urandom_range(0, 9) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_coord();
        logic [31:0] c;
        case ($urandom_range(0, 5))
            3:       c = $urandom_range(0, 8) - 32'd4;
            4: begin
                case ($urandom_range(0, 3))
                    0:       c = 32'h0000_0000;
                    1:       c = 32'h8000_0000;
                    2:       c = 32'h7fff_ffff;
                    default: c = 32'hffff_ffff;
                endcase
            end
            5:       c = 32'd1 << $urandom_range(0, 31);
            default: c = $urandom();
        endcase
        return c;
    endfunction

    task automatic send_item(input tb_mode_t mode, input logic [31:0] x, y, z,
                             input logic occ);
        if (s_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= {occ, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_insert(input logic [31:0] x, y, z, input logic occ);
        send_item(MODE_INSERT, x, y, z, occ);
    endtask

    task automatic send_clear();
        send_item(MODE_CLEAR, $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic write_hash_bits(input logic [HB_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [HB_W-1:0] hb;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset value of hash_bits, chain on one bucket, unoccupied in between
        send_insert(32'd0, 32'd0, 32'd0, 1'b1);
        send_insert(32'd0, 32'd0, 32'd0, 1'b1);
        send_insert(32'd0, 32'd0, 32'd0, 1'b0);
        send_insert(32'd0, 32'd0, 32'd0, 1'b1);
        send_insert(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
        send_insert(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_insert(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_insert(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_insert(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        // clear carrying nonzero fields, then empty buckets again
        send_item(MODE_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_insert(32'd0, 32'd0, 32'd0, 1'b1);
        send_insert(32'd0, 32'd0, 32'd0, 1'b1);
        // hash_bits above the table size
        write_hash_bits(4'd15);
        send_insert(32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9, 1'b1);
        send_insert(32'd0, 32'd0, 32'd0, 1'b1);
        write_hash_bits(4'd14);
        send_insert(32'hffff_ffff, 32'd0, 32'd1, 1'b1);
        // single bucket, mid-build change
        write_hash_bits(4'd0);
        repeat (3) send_insert($urandom(), $urandom(), $urandom(), 1'b1);
        send_insert($urandom(), $urandom(), $urandom(), 1'b0);

        // back to back with no idling and no stalls
        write_hash_bits(4'd4);
        s_gaps   = 1'b0;
        m_stalls = 1'b0;
        send_clear();
        repeat (20)
            send_insert(pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 3) != 0);
        send_clear();
        send_insert(32'd0, 32'd0, 32'd0, 1'b1);

        // many clears, enough to wrap the clear generation
        s_gaps   = 1'b1;
        m_stalls = 1'b1;
        write_hash_bits(4'd1);
        repeat (256) begin
            send_clear();
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3))
                    send_insert($urandom_range(0, 3), $urandom_range(0, 3),
                                $urandom_range(0, 3), 1'b1);
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       hb = 4'd13;
                1:       hb = 4'd0;
                2:       hb = 4'd15;
                3:       hb = 4'd14;
                4:       hb = HB_W'($urandom_range(1, 12));
                default: hb = HB_W'($urandom_range(0, 15));
            endcase
            if (p == 5) begin
                s_gaps   = 1'b0;
                m_stalls = 1'b0;
            end
            write_hash_bits(hb);
            repeat (32) begin
                if ($urandom_range(0, 24) == 0)
                    send_clear();
                else
                    send_insert(pick_coord(), pick_coord(), pick_coord(),
                                $urandom_range(0, 4) != 0);
            end
        end

        drain();
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
